// ===== rtl/gfasu_pkg.sv =====
// Package for the GF(2^8) arithmetic and S-box unit: operation codes, the
// stage payload type and the field arithmetic functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gfasu_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned POLY_W     = 9;
  localparam int unsigned WIDE_W     = 16;
  localparam int unsigned RED_TOP    = 14;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned INV_STAGES = 7;

  localparam logic [POLY_W-1:0]     FIELD_POLY_RESET = 9'h11B;
  localparam logic [BYTE_W-1:0]     AFFINE_CONST     = 8'h63;
  localparam logic [BYTE_W-1:0]     BYTE_MASK        = 8'hFF;
  localparam logic [NIB_W-1:0]      NIB_MASK         = 4'hF;
  localparam logic [BYTE_W-1:0]     GF_ONE           = 8'h01;
  localparam logic [0:0]            REG_FIELD_POLY   = 1'b0;

  typedef enum logic [1:0] {
    ACT_MUL   = 2'd0,
    ACT_XTIME = 2'd1,
    ACT_INV   = 2'd2,
    ACT_SBOX  = 2'd3
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [BYTE_W-1:0] sq;
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] res;
  } stage_data_t;

  function automatic logic [BYTE_W-1:0] clmul4(input logic [NIB_W-1:0] x,
                                               input logic [NIB_W-1:0] y);
    logic [BYTE_W-1:0] r;
    r = '0;
    for (int k = 0; k < NIB_W; k++) begin
      if (y[k]) begin
        r = r ^ (BYTE_W'(x & NIB_MASK) << k);
      end
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] x,
                                               input logic [BYTE_W-1:0] y,
                                               input logic [POLY_W-1:0] poly);
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] mid;
    logic [WIDE_W-1:0] v;
    lo  = clmul4(x[3:0], y[3:0]);
    hi  = clmul4(x[7:4], y[7:4]);
    mid = clmul4(x[3:0] ^ x[7:4], y[3:0] ^ y[7:4]);
    v = (WIDE_W'(hi) << 8) ^ (WIDE_W'(lo ^ mid ^ hi) << 4) ^ WIDE_W'(lo);
    for (int i = RED_TOP; i >= BYTE_W; i--) begin
      if (v[i]) begin
        v = v ^ (WIDE_W'(poly) << (i - BYTE_W));
      end
    end
    return v[BYTE_W-1:0] & BYTE_MASK;
  endfunction

  function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] x,
                                                 input logic [POLY_W-1:0] poly);
    logic [BYTE_W-1:0] r;
    r = {x[BYTE_W-2:0], 1'b0};
    if (x[BYTE_W-1]) begin
      r = r ^ poly[BYTE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] rotl8(input logic [BYTE_W-1:0] v,
                                              input int unsigned n);
    return (v << n) | (v >> (BYTE_W - n));
  endfunction

  function automatic logic [BYTE_W-1:0] aes_affine(input logic [BYTE_W-1:0] x);
    return x ^ rotl8(x, 1) ^ rotl8(x, 2) ^ rotl8(x, 3) ^ rotl8(x, 4) ^ AFFINE_CONST;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gfasu_item_if.sv =====
// Input channel of the GF(2^8) unit: operation code and two operand bytes.
// Depends on gfasu_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gfasu_item_if
  import gfasu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [BYTE_W-1:0] operand_a;
  logic [BYTE_W-1:0] operand_b;

  modport source (output valid, output action, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input action, input operand_a, input operand_b,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/gfasu_result_if.sv =====
// Result channel of the GF(2^8) unit: one result byte per transfer.
// Depends on gfasu_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface gfasu_result_if
  import gfasu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/gfasu_apb_regs.sv =====
// APB-style configuration register holding the reduction polynomial.
// Depends on gfasu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfasu_apb_regs
  import gfasu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [POLY_W-1:0]     field_poly
);

  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_FIELD_POLY);

  always_ff @(posedge clk) begin
    if (rst) begin
      field_poly <= FIELD_POLY_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      field_poly <= pwdata[POLY_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = APB_DATA_W'(field_poly);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gfasu_entry_stage.sv =====
// First pipeline stage: takes an item, forms the product or the doubled byte
// and the first square of operand_a. Depends on gfasu_pkg and gfasu_item_if.
`timescale 1ns / 1ps
`default_nettype none

module gfasu_entry_stage
  import gfasu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [POLY_W-1:0] field_poly,
  gfasu_item_if.sink             item,
  input  wire logic              down_ready,
  output logic                   valid,
  output stage_data_t            data
);

  stage_data_t data_next;
  action_t     act;
  logic        load;

  assign act        = action_t'(item.action);
  assign load       = !valid || down_ready;
  assign item.ready = load;

  always_comb begin
    data_next.action = act;
    data_next.sq     = gf_mul(item.operand_a, item.operand_a, field_poly);
    data_next.acc    = GF_ONE;
    if (act == ACT_MUL) begin
      data_next.res = gf_mul(item.operand_a, item.operand_b, field_poly);
    end else begin
      data_next.res = gf_xtime(item.operand_a, field_poly);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && item.valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gfasu_inv_stage.sv =====
// One step of the inversion chain: squares the running power and folds the
// previous power into the product. Depends on gfasu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfasu_inv_stage
  import gfasu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [POLY_W-1:0] field_poly,
  input  wire logic              up_valid,
  input  wire stage_data_t       up_data,
  output logic                   up_ready,
  input  wire logic              down_ready,
  output logic                   valid,
  output stage_data_t            data
);

  stage_data_t data_next;

  assign up_ready = !valid || down_ready;

  always_comb begin
    data_next     = up_data;
    data_next.sq  = gf_mul(up_data.sq, up_data.sq, field_poly);
    data_next.acc = gf_mul(up_data.acc, up_data.sq, field_poly);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gfasu_out_stage.sv =====
// Output register: selects the result by operation and applies the AES affine
// map for the S-box. Depends on gfasu_pkg and gfasu_result_if.
`timescale 1ns / 1ps
`default_nettype none

module gfasu_out_stage
  import gfasu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        up_valid,
  input  wire stage_data_t up_data,
  output logic             up_ready,
  gfasu_result_if.source   result
);

  logic              valid;
  logic [BYTE_W-1:0] res;
  logic [BYTE_W-1:0] res_next;

  assign up_ready           = !valid || result.ready;
  assign result.valid       = valid;
  assign result.result_byte = res;

  always_comb begin
    unique case (up_data.action)
      ACT_MUL, ACT_XTIME: res_next = up_data.res;
      ACT_INV:            res_next = up_data.acc;
      ACT_SBOX:           res_next = aes_affine(up_data.acc);
      default:            res_next = up_data.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gf256_arith_sbox_unit_core.sv =====
// Top level of the GF(2^8) arithmetic and AES S-box unit.
// Depends on gfasu_pkg, both channel interfaces and the stage modules.
//
// Usage: each transfer on the item channel carries an operation code
// (multiply, xtime, inverse, S-box) and two operand bytes; each transfer on
// the result channel returns one byte, in the order the items arrived.
// The reduction polynomial is written through the APB-style port at byte
// address 0 and should only be changed while the pipeline is empty.
// Every operation takes the same path from an item transfer to its result
// being presented: the entry stage, the inversion stages and the output
// register; one item is taken every cycle unless the receiver stalls.
// The depth is set by the inversion: the first squaring sits in the
// entry stage and seven further register stages each hold one squaring and
// one product step, followed by the output register.
// A synchronous reset empties every stage and restores the polynomial 0x11B.
// When the receiver stalls, each stage holds its item and empty stages still
// fill, so items keep being taken until all nine stages are occupied;
// nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module gf256_arith_sbox_unit_core
  import gfasu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  gfasu_item_if.sink                 item,
  gfasu_result_if.source             result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [POLY_W-1:0] field_poly;
  stage_data_t       data [0:INV_STAGES];
  logic              vld  [0:INV_STAGES];
  logic              rdy  [0:INV_STAGES];

  gfasu_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .field_poly (field_poly)
  );

  gfasu_entry_stage u_entry (
    .clk        (clk),
    .rst        (rst),
    .field_poly (field_poly),
    .item       (item),
    .down_ready (rdy[0]),
    .valid      (vld[0]),
    .data       (data[0])
  );

  for (genvar j = 0; j < INV_STAGES; j++) begin : g_inv
    gfasu_inv_stage u_inv (
      .clk        (clk),
      .rst        (rst),
      .field_poly (field_poly),
      .up_valid   (vld[j]),
      .up_data    (data[j]),
      .up_ready   (rdy[j]),
      .down_ready (rdy[j+1]),
      .valid      (vld[j+1]),
      .data       (data[j+1])
    );
  end

  gfasu_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (vld[INV_STAGES]),
    .up_data  (data[INV_STAGES]),
    .up_ready (rdy[INV_STAGES]),
    .result   (result)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_gf256_arith_sbox_unit_core.sv =====
// Self-checking testbench for gf256_arith_sbox_unit_core: directed and random
// field operations under several reduction polynomials, checked byte by byte.
// Depends on gfasu_pkg, the two channel interfaces and the core from the RTL.
`timescale 1ns / 1ps

module tb_gf256_arith_sbox_unit_core;
  import gfasu_pkg::*;

  typedef struct {
    action_t           op;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
  } field_op_t;

  localparam logic [APB_ADDR_W-1:0] FIELD_POLY_ADDR = APB_ADDR_W'(4 * REG_FIELD_POLY);
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR   = APB_ADDR_W'(4);
  localparam int PHASE_OPS = 172;
  localparam int LONG_HOLD = 300;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  gfasu_item_if   item_if ();
  gfasu_result_if result_if ();

  gf256_arith_sbox_unit_core dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  field_op_t         pending_ops[$];
  logic [BYTE_W-1:0] expected_bytes[$];
  logic [POLY_W-1:0] poly_shadow;
  int                error_count;
  int                result_count;
  int                send_gap;
  int                stall_left;
  bit                quiet;
  bit                hold_armed;
  bit                hold_taken;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] nib_clmul(input logic [NIB_W-1:0] x,
                                                  input logic [NIB_W-1:0] y);
    logic [BYTE_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < NIB_W; k++) begin
      if (y[k]) begin
        acc ^= {4'h0, x} << k;
      end
    end
    return acc;
  endfunction

  function automatic logic [BYTE_W-1:0] field_mul(input logic [BYTE_W-1:0] x,
                                                  input logic [BYTE_W-1:0] y,
                                                  input logic [POLY_W-1:0] poly);
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] mid;
    logic [WIDE_W-1:0] wide;
    lo   = nib_clmul(x[3:0], y[3:0]);
    hi   = nib_clmul(x[7:4], y[7:4]);
    mid  = nib_clmul(x[3:0] ^ x[7:4], y[3:0] ^ y[7:4]);
    wide = {hi, 8'h00} ^ ({8'h00, lo ^ mid ^ hi} << 4) ^ {8'h00, lo};
    for (int i = RED_TOP; i >= BYTE_W; i--) begin
      if (wide[i]) begin
        wide ^= {7'h00, poly} << (i - BYTE_W);
      end
    end
    return wide[BYTE_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] field_double(input logic [BYTE_W-1:0] x,
                                                     input logic [POLY_W-1:0] poly);
    logic [BYTE_W-1:0] r;
    r = {x[BYTE_W-2:0], 1'b0};
    if (x[BYTE_W-1]) begin
      r ^= poly[BYTE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] field_inverse(input logic [BYTE_W-1:0] x,
                                                      input logic [POLY_W-1:0] poly);
    logic [BYTE_W-1:0] sq;
    logic [BYTE_W-1:0] acc;
    sq  = x;
    acc = GF_ONE;
    for (int k = 0; k < INV_STAGES; k++) begin
      sq  = field_mul(sq, sq, poly);
      acc = field_mul(acc, sq, poly);
    end
    return acc;
  endfunction

  function automatic logic [BYTE_W-1:0] byte_rotl(input logic [BYTE_W-1:0] v, input int n);
    logic [WIDE_W-1:0] both;
    both = {v, v} << n;
    return both[WIDE_W-1:BYTE_W];
  endfunction

  function automatic logic [BYTE_W-1:0] sbox_byte(input logic [BYTE_W-1:0] x,
                                                  input logic [POLY_W-1:0] poly);
    logic [BYTE_W-1:0] inv;
    inv = field_inverse(x, poly);
    return inv ^ byte_rotl(inv, 1) ^ byte_rotl(inv, 2) ^ byte_rotl(inv, 3) ^
           byte_rotl(inv, 4) ^ AFFINE_CONST;
  endfunction

  function automatic logic [BYTE_W-1:0] field_result(input action_t op,
                                                     input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [POLY_W-1:0] poly);
    case (op)
      ACT_MUL:   return field_mul(a, b, poly);
      ACT_XTIME: return field_double(a, poly);
      ACT_INV:   return field_inverse(a, poly);
      default:   return sbox_byte(a, poly);
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return GF_ONE;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    $display("[%0t] mismatch on result transfer %0d: %s got %02h want %02h",
             $realtime, result_count, what, got, want);
    error_count++;
  endtask

  task automatic add_op(input action_t op, input logic [BYTE_W-1:0] a,
                        input logic [BYTE_W-1:0] b);
    field_op_t f;
    f.op = op;
    f.a  = a;
    f.b  = b;
    pending_ops.push_back(f);
  endtask

  task automatic add_random_ops(input int n);
    for (int k = 0; k < n; k++) begin
      add_op(action_t'($urandom_range(0, 3)), pick_byte(), pick_byte());
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_ops.size() != 0 || item_if.valid || expected_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == FIELD_POLY_ADDR) begin
      poly_shadow = data[POLY_W-1:0];
    end
  endtask

  task automatic run_phase(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    apb_write(addr, data);
    add_random_ops(PHASE_OPS);
    wait_drained();
  endtask

  // Driver: holds valid high back to back while items are queued and no gap runs.
  always @(posedge clk) begin
    field_op_t next_op;
    logic      offering;
    if (rst) begin
      item_if.valid <= 1'b0;
    end else begin
      offering = item_if.valid;
      if (item_if.valid && item_if.ready) begin
        expected_bytes.push_back(field_result(action_t'(item_if.action), item_if.operand_a,
                                              item_if.operand_b, poly_shadow));
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_ops.size() != 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 17);
          end else begin
            next_op = pending_ops.pop_front();
            item_if.action    <= next_op.op;
            item_if.operand_a <= next_op.a;
            item_if.operand_b <= next_op.b;
            offering = 1'b1;
          end
        end
      end
      item_if.valid <= offering;
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    logic [BYTE_W-1:0] want;
    logic              take;
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected result_byte", result_if.result_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (result_if.result_byte !== want) begin
            report_mismatch("result_byte", result_if.result_byte, want);
          end
        end
        result_count++;
      end
      if (hold_armed && !hold_taken && result_if.valid) begin
        stall_left = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 17);
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      result_if.ready <= take;
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    item_if.valid     = 1'b0;
    item_if.action    = ACT_MUL;
    item_if.operand_a = '0;
    item_if.operand_b = '0;
    result_if.ready   = 1'b0;
    poly_shadow       = FIELD_POLY_RESET;
    error_count       = 0;
    result_count      = 0;
    send_gap          = 0;
    stall_left        = 0;
    quiet             = 1'b0;
    hold_armed        = 1'b0;
    hold_taken        = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset polynomial, operand extremes, the inverse of zero and ignored operand_b.
    add_op(ACT_MUL,   8'h00, 8'h00);
    add_op(ACT_MUL,   8'hFF, 8'hFF);
    add_op(ACT_MUL,   8'h53, 8'hCA);
    add_op(ACT_MUL,   GF_ONE, 8'hAB);
    add_op(ACT_MUL,   8'h80, 8'h02);
    add_op(ACT_XTIME, 8'h80, 8'h00);
    add_op(ACT_XTIME, 8'h7F, 8'hFF);
    add_op(ACT_XTIME, 8'hFF, 8'h5A);
    add_op(ACT_XTIME, 8'h00, 8'hFF);
    add_op(ACT_INV,   8'h00, 8'hFF);
    add_op(ACT_INV,   GF_ONE, 8'h00);
    add_op(ACT_INV,   8'hFF, 8'h3C);
    add_op(ACT_INV,   8'h53, 8'hFF);
    add_op(ACT_SBOX,  8'h00, 8'h00);
    add_op(ACT_SBOX,  GF_ONE, 8'hFF);
    add_op(ACT_SBOX,  8'hFF, 8'hC3);
    add_op(ACT_SBOX,  8'h53, 8'h00);
    add_op(ACT_SBOX,  8'h00, 8'hFF);
    wait_drained();

    run_phase(FIELD_POLY_ADDR, 32'h0000_0100);
    hold_armed = 1'b1;
    run_phase(FIELD_POLY_ADDR, 32'h0000_01FF);
    run_phase(FIELD_POLY_ADDR, 32'h0000_001B);
    run_phase(FIELD_POLY_ADDR, 32'(9'h100 + $urandom_range(0, 255)));
    run_phase(UNMAPPED_ADDR, 32'h0000_00AB);
    run_phase(FIELD_POLY_ADDR, 32'hA5A5_A71D);
    run_phase(FIELD_POLY_ADDR, 32'h0000_0000);
    quiet = 1'b1;
    run_phase(FIELD_POLY_ADDR, 32'(FIELD_POLY_RESET));

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gfasu_pkg.sv
rtl/gfasu_item_if.sv
rtl/gfasu_result_if.sv
rtl/gfasu_apb_regs.sv
rtl/gfasu_entry_stage.sv
rtl/gfasu_inv_stage.sv
rtl/gfasu_out_stage.sv
rtl/gf256_arith_sbox_unit_core.sv
tb/sv/tb_gf256_arith_sbox_unit_core.sv
